FILE: hw/rtl/cspic_pkg.sv
// Shared types, widths, step codes and helpers for the cross-section Pearson block.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none
package cspic_pkg;

    // Default parameter values
    localparam int ROW_LEN_MAX_DEF = 1024;
    localparam int ROWS_MAX_DEF    = 1048576;
    localparam int SAMPLE_BITS_DEF = 24;

    // Port widths
    localparam int IN_W  = 24;
    localparam int ID_W  = 48;   // input tdata
    localparam int IU_W  = 3;    // input tuser
    localparam int OD_W  = 128;  // output tdata
    localparam int OU_W  = 2;    // output tuser

    // Row sums, sized for the largest row length (4096 pairs)
    localparam int CNT_W = 13;
    localparam int SX_W  = 36;
    localparam int SXY_W = 60;
    localparam int SXX_W = 59;

    // Shared arithmetic units
    localparam int MW    = 72;   // multiplier operand
    localparam int PW    = 144;  // product and divisor
    localparam int QW    = 61;   // quotient
    localparam int SQW   = 102;  // square root radicand
    localparam int RW    = 51;   // square root result
    localparam int UC_W  = 7;    // iteration counter

    // Panel totals
    localparam int CT_W  = 52;
    localparam int CST_W = 51;
    localparam int VR_W  = 21;

    // Unit codes
    localparam logic [1:0] U_MUL  = 2'd0;
    localparam logic [1:0] U_DIV  = 2'd1;
    localparam logic [1:0] U_SQRT = 2'd2;
    localparam logic [1:0] U_NONE = 2'd3;

    // Sequencer steps
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STP_NXY   = 5'd0;
    localparam logic [STEP_W-1:0] STP_XY    = 5'd1;
    localparam logic [STEP_W-1:0] STP_NXX   = 5'd2;
    localparam logic [STEP_W-1:0] STP_XX    = 5'd3;
    localparam logic [STEP_W-1:0] STP_NYY   = 5'd4;
    localparam logic [STEP_W-1:0] STP_YY    = 5'd5;
    localparam logic [STEP_W-1:0] STP_NUM2  = 5'd6;
    localparam logic [STEP_W-1:0] STP_DEN   = 5'd7;
    localparam logic [STEP_W-1:0] STP_RDIV  = 5'd8;
    localparam logic [STEP_W-1:0] STP_RSQRT = 5'd9;
    localparam logic [STEP_W-1:0] STP_QSQ   = 5'd10;
    localparam logic [STEP_W-1:0] STP_ROW   = 5'd11;
    localparam logic [STEP_W-1:0] STP_CSQ   = 5'd12;
    localparam logic [STEP_W-1:0] STP_TSQ   = 5'd13;
    localparam logic [STEP_W-1:0] STP_MEAN  = 5'd14;
    localparam logic [STEP_W-1:0] STP_VSQRT = 5'd15;
    localparam logic [STEP_W-1:0] STP_STD   = 5'd16;
    localparam logic [STEP_W-1:0] STP_RATIO = 5'd17;
    localparam logic [STEP_W-1:0] STP_PANEL = 5'd18;

    // Controller to datapath
    typedef struct packed {
        logic                acc;
        logic                start;
        logic [STEP_W-1:0]   step;
        logic                emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic done;
        logic eop;
        logic out_free;
    } t_sts;

    // Unit that carries out a step
    function automatic logic [1:0] unit_of(input logic [STEP_W-1:0] step);
        logic [1:0] u;
        unique case (step) inside
            STP_RDIV, STP_MEAN, STP_STD, STP_RATIO: u = U_DIV;
            STP_RSQRT, STP_VSQRT:                   u = U_SQRT;
            STP_ROW, STP_PANEL:                     u = U_NONE;
            default:                                u = U_MUL;
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/cspic_ctrl.sv
// Step sequencer for the cross-section Pearson block.
// Depends on cspic_pkg; drives the datapath through t_cmd and reads t_sts.
`timescale 1ns / 1ps
`default_nettype none
module cspic_ctrl
    import cspic_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    input  wire logic i_eor,
    input  wire logic i_eop,
    output logic      o_s_tready,
    output t_cmd      o_cmd,
    input  t_sts      i_sts
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              w_acc;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;

    // Command word
    always_comb begin
        o_cmd.acc   = w_acc;
        o_cmd.start = (r_state == S_ISSUE);
        o_cmd.step  = r_step;
        o_cmd.emit  = (r_state == S_OUT) && i_sts.out_free;
    end

    // Walk the steps of a row, and of a panel when it closes
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && (i_eor || i_eop)) begin
                    n_step  = STP_NXY;
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.done) begin
                    if ((r_step == STP_ROW && !i_sts.eop) || r_step == STP_PANEL) begin
                        n_state = S_OUT;
                    end else begin
                        n_step  = r_step + 1'b1;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= STP_NXY;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/cspic_dp.sv
// Datapath: row sums, shared shift-add multiplier, restoring divider and square
// root unit, panel totals and the output register. Depends on cspic_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cspic_dp
    import cspic_pkg::*;
#(
    parameter int ROW_LEN_MAX = ROW_LEN_MAX_DEF,
    parameter int ROWS_MAX    = ROWS_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [IN_W-1:0] i_x,
    input  wire logic [IN_W-1:0] i_y,
    input  wire logic            i_xf,
    input  wire logic            i_yf,
    input  wire logic            i_eop,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic                 o_m_tvalid,
    input  wire logic            i_m_tready,
    output logic [OD_W-1:0]      o_m_tdata,
    output logic [OU_W-1:0]      o_m_tuser
);

    localparam int SH = IN_W - SAMPLE_BITS;
    localparam logic [QW-1:0] STD_CAP = QW'(64'd1073741824);

    // Row sums
    logic signed [SX_W-1:0]  r_sx, r_sy;
    logic signed [SXY_W-1:0] r_sxy;
    logic [SXX_W-1:0]        r_sxx, r_syy;
    logic [CNT_W-1:0]        r_n;
    logic                    r_eop;

    // Step results
    logic [PW-1:0] r_p1, r_p2, r_pa, r_pb, r_pc, r_pd, r_num2, r_den;
    logic          r_neg, r_valid;

    // Shared units
    logic [PW-1:0]   r_ma, r_prod;
    logic [MW-1:0]   r_mb;
    logic [PW-1:0]   r_drem, r_dd;
    logic [QW-1:0]   r_ddb, r_dq;
    logic [SQW-1:0]  r_srad;
    logic [RW+1:0]   r_srem;
    logic [RW-1:0]   r_sroot;
    logic            r_busy, r_done;
    logic [1:0]      r_unit;
    logic [UC_W-1:0] r_cnt;

    // Panel totals and results
    logic signed [CT_W-1:0] r_ct;
    logic [CST_W-1:0]       r_cst;
    logic [VR_W-1:0]        r_vr;
    logic [30:0]            r_meanmag, r_stdq;
    logic signed [31:0]     r_corr, r_mean, r_ratio;
    logic [30:0]            r_std;
    logic                   r_cvalid;

    // Output register
    logic            r_ov;
    logic [OD_W-1:0] r_od;
    logic [OU_W-1:0] r_ou;

    // Sample decode and products
    logic signed [IN_W-1:0]   w_x, w_y;
    logic signed [2*IN_W-1:0] w_xy, w_xx, w_yy;
    logic                     w_take;

    assign w_x    = $signed(i_x << SH) >>> SH;
    assign w_y    = $signed(i_y << SH) >>> SH;
    assign w_xy   = w_x * w_y;
    assign w_xx   = w_x * w_x;
    assign w_yy   = w_y * w_y;
    assign w_take = i_xf && i_yf && (r_n < CNT_W'(ROW_LEN_MAX));

    // Magnitudes and the signed numerator
    logic [SX_W-1:0]      w_absx, w_absy;
    logic [SXY_W-1:0]     w_absxy;
    logic [CT_W-1:0]      w_ctabs;
    logic                 w_n1, w_n2;
    logic signed [PW:0]   w_s1, w_s2;
    logic signed [PW+1:0] w_num;
    logic [PW+1:0]        w_numabs;
    logic [30:0]          w_q;
    logic signed [31:0]   w_corr;
    logic [PW-1:0]        w_va;
    logic [SQW-1:0]       w_v;

    assign w_absx   = r_sx[SX_W-1] ? $unsigned(-r_sx) : $unsigned(r_sx);
    assign w_absy   = r_sy[SX_W-1] ? $unsigned(-r_sy) : $unsigned(r_sy);
    assign w_absxy  = r_sxy[SXY_W-1] ? $unsigned(-r_sxy) : $unsigned(r_sxy);
    assign w_ctabs  = r_ct[CT_W-1] ? $unsigned(-r_ct) : $unsigned(r_ct);
    assign w_n1     = r_sxy[SXY_W-1];
    assign w_n2     = r_sx[SX_W-1] ^ r_sy[SX_W-1];
    assign w_s1     = w_n1 ? -$signed({1'b0, r_p1}) : $signed({1'b0, r_p1});
    assign w_s2     = w_n2 ? -$signed({1'b0, r_p2}) : $signed({1'b0, r_p2});
    assign w_num    = (PW+2)'(w_s1) - (PW+2)'(w_s2);
    assign w_numabs = w_num[PW+1] ? $unsigned(-w_num) : $unsigned(w_num);
    assign w_q      = r_sroot[30:0];
    assign w_corr   = !r_valid ? 32'sd0 :
                      (r_neg ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q}));
    assign w_va     = r_pa << 30;
    assign w_v      = (w_va > r_pb) ? SQW'(w_va - r_pb) : '0;

    // Operand selection per step
    logic [MW-1:0]  w_ma, w_mb;
    logic [PW-1:0]  w_dr0, w_dd;
    logic [QW-1:0]  w_ddb;
    logic [SQW-1:0] w_rad;

    always_comb begin
        w_ma  = '0;
        w_mb  = '0;
        w_dr0 = '0;
        w_dd  = '0;
        w_ddb = '0;
        w_rad = '0;
        case (i_cmd.step)
            STP_NXY: begin
                w_ma = MW'(r_n);
                w_mb = MW'(w_absxy);
            end
            STP_XY: begin
                w_ma = MW'(w_absx);
                w_mb = MW'(w_absy);
            end
            STP_NXX: begin
                w_ma = MW'(r_n);
                w_mb = MW'(r_sxx);
            end
            STP_XX: begin
                w_ma = MW'(w_absx);
                w_mb = MW'(w_absx);
            end
            STP_NYY: begin
                w_ma = MW'(r_n);
                w_mb = MW'(r_syy);
            end
            STP_YY: begin
                w_ma = MW'(w_absy);
                w_mb = MW'(w_absy);
            end
            STP_NUM2: begin
                w_ma = MW'(w_numabs);
                w_mb = MW'(w_numabs);
            end
            STP_DEN: begin
                w_ma = MW'(r_pa - r_pb);
                w_mb = MW'(r_pc - r_pd);
            end
            STP_QSQ: begin
                w_ma = MW'(w_q);
                w_mb = MW'(w_q);
            end
            STP_CSQ: begin
                w_ma = MW'(r_vr);
                w_mb = MW'(r_cst);
            end
            STP_TSQ: begin
                w_ma = MW'(w_ctabs);
                w_mb = MW'(w_ctabs);
            end
            STP_RDIV: begin
                w_dr0 = r_num2 >> 1;
                w_ddb = {r_num2[0], {(QW-1){1'b0}}};
                w_dd  = r_den;
            end
            STP_MEAN: begin
                w_ddb = QW'(w_ctabs);
                w_dd  = PW'(r_vr);
            end
            STP_STD: begin
                w_ddb = QW'(r_sroot);
                w_dd  = PW'(r_vr);
            end
            STP_RATIO: begin
                w_ddb = QW'({r_meanmag, 16'd0});
                w_dd  = PW'(r_stdq);
            end
            STP_RSQRT: w_rad = SQW'(r_dq);
            STP_VSQRT: w_rad = w_v;
            default: ;
        endcase
    end

    // Iteration steps of the divider and square root
    logic [PW:0]   w_dt;
    logic [RW+3:0] w_st, w_trial;

    assign w_dt    = {r_drem, r_ddb[QW-1]};
    assign w_st    = {r_srem, r_srad[SQW-1 -: 2]};
    assign w_trial = (RW+4)'({r_sroot, 2'b01});

    // Panel results
    logic                w_has;
    logic signed [31:0]  w_mean, w_ratio;

    assign w_has  = (r_vr != '0);
    assign w_mean = r_ct[CT_W-1] ? -$signed({1'b0, r_meanmag}) : $signed({1'b0, r_meanmag});

    always_comb begin
        w_ratio = 32'sd0;
        if (w_has && r_stdq != '0) begin
            if (r_ct[CT_W-1]) begin
                w_ratio = (r_dq > QW'(64'd2147483648)) ? 32'sh80000000 :
                          -$signed(r_dq[31:0]);
            end else begin
                w_ratio = (r_dq > QW'(64'd2147483647)) ? 32'sh7fffffff :
                          $signed(r_dq[31:0]);
            end
        end
    end

    // Unit control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_unit <= U_NONE;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_unit <= unit_of(i_cmd.step);
                case (unit_of(i_cmd.step))
                    U_MUL: begin
                        r_busy <= 1'b1;
                        r_cnt  <= UC_W'(MW);
                    end
                    U_DIV: begin
                        r_busy <= 1'b1;
                        r_cnt  <= UC_W'(QW);
                    end
                    U_SQRT: begin
                        r_busy <= 1'b1;
                        r_cnt  <= UC_W'(RW);
                    end
                    default: r_done <= 1'b1;
                endcase
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == UC_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Unit datapaths: load on start, iterate while busy
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ma    <= PW'(w_ma);
            r_mb    <= w_mb;
            r_prod  <= '0;
            r_drem  <= w_dr0;
            r_ddb   <= w_ddb;
            r_dd    <= w_dd;
            r_dq    <= (unit_of(i_cmd.step) == U_DIV) ? '0 : r_dq;
            r_srad  <= w_rad;
            r_srem  <= (unit_of(i_cmd.step) == U_SQRT) ? '0 : r_srem;
            r_sroot <= (unit_of(i_cmd.step) == U_SQRT) ? '0 : r_sroot;
        end else if (r_busy) begin
            case (r_unit)
                U_MUL: begin
                    if (r_mb[0]) begin
                        r_prod <= r_prod + r_ma;
                    end
                    r_ma <= r_ma << 1;
                    r_mb <= r_mb >> 1;
                end
                U_DIV: begin
                    r_ddb <= r_ddb << 1;
                    if (w_dt >= {1'b0, r_dd}) begin
                        r_drem <= PW'(w_dt - {1'b0, r_dd});
                        r_dq   <= {r_dq[QW-2:0], 1'b1};
                    end else begin
                        r_drem <= w_dt[PW-1:0];
                        r_dq   <= {r_dq[QW-2:0], 1'b0};
                    end
                end
                U_SQRT: begin
                    r_srad <= r_srad << 2;
                    if (w_st >= w_trial) begin
                        r_srem  <= (RW+2)'(w_st - w_trial);
                        r_sroot <= {r_sroot[RW-2:0], 1'b1};
                    end else begin
                        r_srem  <= (RW+2)'(w_st);
                        r_sroot <= {r_sroot[RW-2:0], 1'b0};
                    end
                end
                default: ;
            endcase
        end
    end

    // Store step results when a unit finishes
    always_ff @(posedge i_clk) begin
        if (r_done) begin
            case (i_cmd.step)
                STP_NXY:  r_p1 <= r_prod;
                STP_XY:   r_p2 <= r_prod;
                STP_NXX:  r_pa <= r_prod;
                STP_XX:   r_pb <= r_prod;
                STP_NYY:  r_pc <= r_prod;
                STP_YY:   r_pd <= r_prod;
                STP_NUM2: r_num2 <= r_prod;
                STP_DEN:  r_den <= r_prod;
                STP_QSQ:  r_pa <= r_prod;
                STP_CSQ:  r_pa <= r_prod;
                STP_TSQ:  r_pb <= r_prod;
                STP_MEAN: r_meanmag <= r_dq[30:0];
                STP_STD:  r_stdq <= (r_dq > STD_CAP) ? STD_CAP[30:0] : r_dq[30:0];
                default: ;
            endcase
        end
        // Sign and validity of the row, taken once the six products stand
        if (i_cmd.start && i_cmd.step == STP_NUM2) begin
            r_neg   <= w_num[PW+1];
            r_valid <= (r_n >= CNT_W'(3)) && (r_pa > r_pb) && (r_pc > r_pd);
        end
    end

    // Row sums and panel totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxy <= '0;
            r_sxx <= '0;
            r_syy <= '0;
            r_n   <= '0;
            r_eop <= 1'b0;
            r_ct  <= '0;
            r_cst <= '0;
            r_vr  <= '0;
        end else if (i_cmd.acc) begin
            r_eop <= i_eop;
            if (w_take) begin
                r_sx  <= r_sx + SX_W'(w_x);
                r_sy  <= r_sy + SX_W'(w_y);
                r_sxy <= r_sxy + SXY_W'(w_xy);
                r_sxx <= r_sxx + SXX_W'($unsigned(w_xx));
                r_syy <= r_syy + SXX_W'($unsigned(w_yy));
                r_n   <= r_n + 1'b1;
            end
        end else if (i_cmd.start && i_cmd.step == STP_ROW) begin
            // Fold a valid row into the totals while fewer than ROWS_MAX rows stand, then drop the row sums
            if (r_valid && r_vr < VR_W'(ROWS_MAX)) begin
                r_ct  <= r_ct + CT_W'(w_corr);
                r_cst <= r_cst + CST_W'(r_pa[60:30]);
                r_vr  <= r_vr + 1'b1;
            end
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxy <= '0;
            r_sxx <= '0;
            r_syy <= '0;
            r_n   <= '0;
        end else if (i_cmd.start && i_cmd.step == STP_PANEL) begin
            r_ct  <= '0;
            r_cst <= '0;
            r_vr  <= '0;
        end
    end

    // Result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.start && i_cmd.step == STP_ROW) begin
            r_corr   <= w_corr;
            r_cvalid <= r_valid;
            r_mean   <= 32'sd0;
            r_std    <= '0;
            r_ratio  <= 32'sd0;
        end else if (i_cmd.start && i_cmd.step == STP_PANEL) begin
            r_mean  <= w_has ? w_mean : 32'sd0;
            r_std   <= w_has ? r_stdq : '0;
            r_ratio <= w_ratio;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_od <= {1'b0, r_ratio, r_std, r_mean, r_corr};
            r_ou <= {r_eop, r_cvalid};
        end
    end

    assign o_m_tvalid   = r_ov;
    assign o_m_tdata    = r_od;
    assign o_m_tuser    = r_ou;
    assign o_sts.done     = r_done;
    assign o_sts.eop      = r_eop;
    assign o_sts.out_free = !r_ov || i_m_tready;

endmodule
`default_nettype wire

FILE: hw/rtl/cross_section_pearson_ic.sv
// Sequencing: a row end runs nine shift-add products, a restoring divide and a square root on
// the shared units, one step after another; a panel end adds two products, three divides and
// one root. Throughput: one word per cycle inside a row; the input then stays closed until
// the row's result word has been loaded into the output register.
// Reset: i_rst_n synchronous, active low; clears row sums, panel totals and the sequencer.
// Depends on cspic_pkg, cspic_ctrl and cspic_dp.
`timescale 1ns / 1ps
`default_nettype none
module cross_section_pearson_ic
    import cspic_pkg::*;
#(
    parameter int ROW_LEN_MAX = ROW_LEN_MAX_DEF,
    parameter int ROWS_MAX    = ROWS_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    input  wire logic [ID_W-1:0] i_s_tdata,  // sample_x, sample_y
    input  wire logic            i_s_tlast,  // end_of_row
    input  wire logic [IU_W-1:0] i_s_tuser,  // x_finite, y_finite, end_of_panel
    output logic                 o_m_tvalid,
    input  wire logic            i_m_tready,
    output logic [OD_W-1:0]      o_m_tdata,  // row_corr, mean_corr, std_corr, info_ratio, pad
    output logic [OU_W-1:0]      o_m_tuser   // row_corr_valid, is_summary
);

    t_cmd w_cmd;
    t_sts w_sts;

    cspic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_eor      (i_s_tlast),
        .i_eop      (i_s_tuser[2]),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    cspic_dp #(
        .ROW_LEN_MAX (ROW_LEN_MAX),
        .ROWS_MAX    (ROWS_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_x        (i_s_tdata[IN_W-1:0]),
        .i_y        (i_s_tdata[2*IN_W-1:IN_W]),
        .i_xf       (i_s_tuser[0]),
        .i_yf       (i_s_tuser[1]),
        .i_eop      (i_s_tuser[2]),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/cspic_chk.sv
// Port-level checks for cross_section_pearson_ic, bound to the top level.
// Depends on cspic_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cspic_chk
    import cspic_pkg::*;
(
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_s_tvalid,
    input wire logic            o_s_tready,
    input wire logic [ID_W-1:0] i_s_tdata,
    input wire logic            i_s_tlast,
    input wire logic [IU_W-1:0] i_s_tuser,
    input wire logic            o_m_tvalid,
    input wire logic            i_m_tready,
    input wire logic [OD_W-1:0] o_m_tdata,
    input wire logic [OU_W-1:0] o_m_tuser
);

    // Hold a stalled result word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result word changed");

    // Summary fields stay zero on a plain row word
    a_nosum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[1] |-> o_m_tdata[126:32] == '0)
        else $error("summary fields set on a non-summary word");

    // An invalid row carries a zero correlation
    a_inval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata[31:0] == '0)
        else $error("invalid row with nonzero correlation");

    // Standard deviation never exceeds one
    a_std: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[94:64] <= 31'h40000000)
        else $error("std above one");

    // Input closes after a row end is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tlast || i_s_tuser[2]) |=> !o_s_tready)
        else $error("input open during row computation");

endmodule

bind cross_section_pearson_ic cspic_chk u_chk (.*);
`default_nettype wire
